// ===== hdl/gsff_pkg.sv =====
// shared types, codes and header table of the gnss sentence framer filter
`timescale 1ns / 1ps

package gsff_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int HDR_KEEP         = 9;
    localparam int TYPE_COUNT       = 12;
    localparam int QUEUE_DEPTH      = 2;

    localparam int MASK_W   = 12;
    localparam int TYPE_W   = 4;
    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int ADDR_W   = 3;

    localparam logic [ADDR_W-1:0] ADDR_TYPE_ENABLE_MASK = 3'd0;
    localparam logic [MASK_W-1:0] MASK_RESET            = 12'hfff;

    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;

    // byte class decided by the front end
    typedef logic [1:0] byte_class_t;
    localparam byte_class_t CLS_DATA  = 2'd0;
    localparam byte_class_t CLS_START = 2'd1;
    localparam byte_class_t CLS_LF    = 2'd2;

    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
    } queue_entry_t;

    // headers left-justified, first character in the top byte
    localparam logic [HDR_KEEP*8-1:0] HDR_TEXT [TYPE_COUNT] = '{
        {"$GPGGA", 24'h0}, {"$GNGGA", 24'h0}, {"$BDGGA", 24'h0},
        {"$GPVTG", 24'h0}, {"$GNVTG", 24'h0}, {"$BDVTG", 24'h0},
        {"$GPZDA", 24'h0}, {"$GNZDA", 24'h0}, {"$BDZDA", 24'h0},
        "#HEADINGA", "#BESTPOSA", {"#AGRICA", 16'h0}
    };

    localparam logic [3:0] HDR_LEN [TYPE_COUNT] = '{
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd9, 4'd9, 4'd7
    };

endpackage

// ===== hdl/gsff_front.sv =====
// front end: byte classification and the two-entry queue to the back end
`timescale 1ns / 1ps

module gsff_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    output logic                  q_valid,
    output gsff_pkg::queue_entry_t q_entry,
    input  logic                  q_pop
);
    import gsff_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    queue_entry_t     new_entry;
    logic             push;
    logic             pop;

    always_comb
    begin
        new_entry.data = rx_byte;
        if (rx_byte == CH_DOLLAR || rx_byte == CH_HASH)
        begin
            new_entry.cls = CLS_START;
        end
        else if (rx_byte == CH_LF)
        begin
            new_entry.cls = CLS_LF;
        end
        else
        begin
            new_entry.cls = CLS_DATA;
        end
    end

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// ===== hdl/gsff_back.sv =====
// back end: frame position tracking, header compare and result register
`timescale 1ns / 1ps

module gsff_back #(
    parameter int BUFFER_BYTES = gsff_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  gsff_pkg::queue_entry_t        q_entry,
    output logic                          q_pop,
    input  logic [gsff_pkg::MASK_W-1:0]   type_enable_mask,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          byte_stored,
    output logic [gsff_pkg::INDEX_W-1:0]  store_index,
    output logic                          frame_end,
    output logic                          frame_accepted,
    output logic [gsff_pkg::TYPE_W-1:0]   sentence_type,
    output logic [gsff_pkg::LENGTH_W-1:0] frame_length
);
    import gsff_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);
    localparam int EXT_W = POS_W + LENGTH_W;

    logic [POS_W-1:0] wp_reg, wp_next;
    logic [7:0]       hdr_reg [HDR_KEEP];
    logic [7:0]       hdr_next [HDR_KEEP];
    logic [7:0]       last_reg, last_next;

    logic                out_valid_reg;
    logic                stored_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                fend_reg;
    logic                acc_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [LENGTH_W-1:0] length_reg;

    logic [POS_W-1:0]    pos0;
    logic [POS_W-1:0]    spos;
    logic                store;
    logic                fend;
    logic [TYPE_COUNT-1:0] hit;
    logic                any_hit;
    logic [TYPE_W-1:0]   hit_type;
    logic                acc;
    logic [EXT_W-1:0]    idx_ext;
    logic [EXT_W-1:0]    len_ext;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    // a full buffer wraps before the byte is handled
    assign pos0 = (wp_reg >= POS_W'(BUFFER_BYTES)) ? '0 : wp_reg;

    always_comb
    begin
        store = 1'b0;
        fend  = 1'b0;
        spos  = pos0;
        unique case (q_entry.cls)
            CLS_START:
            begin
                store = 1'b1;
                spos  = '0;
            end
            CLS_LF:
            begin
                // bare line feed or line feed at position zero is dropped
                if (pos0 != '0 && last_reg == CH_CR)
                begin
                    store = 1'b1;
                    fend  = 1'b1;
                end
            end
            CLS_DATA:
            begin
                store = 1'b1;
            end
            default:
            begin
                store = 1'b0;
            end
        endcase
    end

    assign wp_next   = store ? spos + 1'b1 : pos0;
    assign last_next = store ? q_entry.data : last_reg;

    always_comb
    begin
        for (int k = 0; k < HDR_KEEP; k++)
        begin
            hdr_next[k] = hdr_reg[k];
            if (store && spos == POS_W'(k))
            begin
                hdr_next[k] = q_entry.data;
            end
        end
    end

    // header compare on the bytes as they stand after this store
    always_comb
    begin
        for (int t = 0; t < TYPE_COUNT; t++)
        begin
            hit[t] = 1'b1;
            for (int k = 0; k < HDR_KEEP; k++)
            begin
                if (4'(k) < HDR_LEN[t] &&
                    hdr_next[k] != HDR_TEXT[t][HDR_KEEP*8-1-8*k -: 8])
                begin
                    hit[t] = 1'b0;
                end
            end
        end
    end

    // lowest matching type wins
    always_comb
    begin
        hit_type = '0;
        for (int t = TYPE_COUNT - 1; t >= 0; t--)
        begin
            if (hit[t])
            begin
                hit_type = TYPE_W'(t);
            end
        end
    end

    assign any_hit = |hit;
    assign acc     = fend && any_hit && type_enable_mask[hit_type];
    assign idx_ext = store ? EXT_W'(spos) : '0;
    assign len_ext = fend ? EXT_W'(wp_next) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < HDR_KEEP; k++)
            begin
                hdr_reg[k] <= '0;
            end
        end
        else
        begin
            if (q_pop)
            begin
                wp_reg   <= wp_next;
                last_reg <= last_next;
                for (int k = 0; k < HDR_KEEP; k++)
                begin
                    hdr_reg[k] <= hdr_next[k];
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            stored_reg <= store;
            index_reg  <= idx_ext[INDEX_W-1:0];
            fend_reg   <= fend;
            acc_reg    <= acc;
            type_reg   <= acc ? hit_type : '0;
            length_reg <= len_ext[LENGTH_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_stored    = stored_reg;
    assign store_index    = index_reg;
    assign frame_end      = fend_reg;
    assign frame_accepted = acc_reg;
    assign sentence_type  = type_reg;
    assign frame_length   = length_reg;

endmodule

// ===== hdl/gnss_sentence_framer_filter.sv =====
// top level of the gnss sentence framer filter
//
//  channel   direction  handshake           payload
//  rx        in         in_valid/in_ready   rx_byte
//  result    out        out_valid/out_ready byte_stored, store_index, frame_end,
//                                           frame_accepted, sentence_type, frame_length
//  config    in         apb (psel/penable)  type_enable_mask at byte address 0
//
// one transaction per cycle sustained in both directions while out_ready stays high
// a byte passes through the front queue and then the result register
// the back end decides a byte combinationally, header compare included
// a stalled result keeps the back end waiting while the two-entry queue fills
// asynchronous active-low reset clears positions, header copies and the mask to all ones
`timescale 1ns / 1ps

module gnss_sentence_framer_filter #(
    parameter int BUFFER_BYTES = gsff_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // apb configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsff_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // received bytes
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    // results
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          byte_stored,
    output logic [gsff_pkg::INDEX_W-1:0]  store_index,
    output logic                          frame_end,
    output logic                          frame_accepted,
    output logic [gsff_pkg::TYPE_W-1:0]   sentence_type,
    output logic [gsff_pkg::LENGTH_W-1:0] frame_length
);
    import gsff_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic              cfg_write;
    logic              q_valid;
    logic              q_pop;
    queue_entry_t      q_entry;

    // register write on the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_TYPE_ENABLE_MASK) ? 32'(mask_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_write && paddr == ADDR_TYPE_ENABLE_MASK)
        begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    // front end classifies bytes and buffers them
    gsff_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    // back end tracks the frame and produces one result per byte
    gsff_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop),
        .type_enable_mask (mask_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .byte_stored      (byte_stored),
        .store_index      (store_index),
        .frame_end        (frame_end),
        .frame_accepted   (frame_accepted),
        .sentence_type    (sentence_type),
        .frame_length     (frame_length)
    );

endmodule

// ===== hdl/gsff_checker.sv =====
// port-level assertions for the gnss sentence framer filter and their bind
`timescale 1ns / 1ps

module gsff_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          byte_stored,
    input logic [gsff_pkg::INDEX_W-1:0]  store_index,
    input logic                          frame_end,
    input logic                          frame_accepted,
    input logic [gsff_pkg::TYPE_W-1:0]   sentence_type,
    input logic [gsff_pkg::LENGTH_W-1:0] frame_length
);
    import gsff_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(store_index) && $stable(frame_end))
        else $error("result changed while stalled");

    // frame end stores the line feed right after the length so far
    a_end_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |->
            byte_stored && frame_length[INDEX_W-1:0] == INDEX_W'(store_index + 1'b1))
        else $error("frame end without matching store");

    a_acc_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_accepted |-> frame_end)
        else $error("accepted without frame end");

    a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_accepted |-> sentence_type == '0)
        else $error("sentence type set on rejected result");

endmodule

bind gnss_sentence_framer_filter gsff_checker u_gsff_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_stored    (byte_stored),
    .store_index    (store_index),
    .frame_end      (frame_end),
    .frame_accepted (frame_accepted),
    .sentence_type  (sentence_type),
    .frame_length   (frame_length)
);
